// ----- sv/vpfp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vpfp_pkg
// Shared types and constants for the virtual-link probe frame parser.
// ---------------------------------------------------------------------------
package vpfp_pkg;

    localparam int unsigned POS_W  = 6;
    localparam int unsigned ADDR_W = 3;

    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

    localparam logic [15:0] PORT_RESET  = 16'd100;
    localparam logic [31:0] MAGIC_RESET = 32'd0;

    localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
    localparam logic [POS_W-1:0] POS_VLAN_LO  = 6'd15;
    localparam logic [POS_W-1:0] HDR_UNTAGGED = 6'd14;
    localparam logic [POS_W-1:0] HDR_TAGGED   = 6'd18;
    localparam logic [POS_W-1:0] POS_MIN_LAST = 6'd57;
    localparam logic [POS_W-1:0] POS_MAX      = 6'd63;

    // offsets from the IPv4 header start
    localparam logic [POS_W-1:0] REL_VERSION  = 6'd0;
    localparam logic [POS_W-1:0] REL_PROTOCOL = 6'd9;
    localparam logic [POS_W-1:0] REL_SRC_PORT = 6'd21;
    localparam logic [POS_W-1:0] REL_DST_PORT = 6'd23;
    localparam logic [POS_W-1:0] REL_MAGIC    = 6'd31;
    localparam logic [POS_W-1:0] REL_LINK     = 6'd33;
    localparam logic [POS_W-1:0] REL_SOURCE   = 6'd34;
    localparam logic [POS_W-1:0] REL_SEQUENCE = 6'd39;

    localparam logic REG_MAGIC = 1'b0;
    localparam logic REG_PORT  = 1'b1;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] probe_port;
    } t_cfg;

    typedef struct packed {
        logic        matched;
        logic [15:0] link_id;
        logic [7:0]  source_port;
        logic [31:0] seq_number;
        logic [11:0] vlan_id;
    } t_result;

endpackage
`default_nettype wire

// ----- sv/vpfp_cfg_regs.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vpfp_cfg_regs
// APB register file: expected magic and probe UDP port.
// ---------------------------------------------------------------------------
module vpfp_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vpfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output vpfp_pkg::t_cfg                   o_cfg
);

    logic [31:0] r_magic;
    logic [15:0] r_port;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= vpfp_pkg::MAGIC_RESET;
            r_port  <= vpfp_pkg::PORT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                vpfp_pkg::REG_MAGIC: r_magic <= pwdata;
                vpfp_pkg::REG_PORT:  r_port  <= pwdata[15:0];
                default:             r_magic <= r_magic;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vpfp_pkg::REG_MAGIC: prdata = r_magic;
            vpfp_pkg::REG_PORT:  prdata = {16'd0, r_port};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.magic      = r_magic;
    assign o_cfg.probe_port = r_port;

endmodule
`default_nettype wire

// ----- sv/vpfp_parser.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vpfp_parser
// Per-frame parse state and the single-pass byte check and capture logic.
// ---------------------------------------------------------------------------
module vpfp_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    input  wire vpfp_pkg::t_cfg i_cfg,
    output vpfp_pkg::t_result   o_result
);

    logic [vpfp_pkg::POS_W-1:0] r_pos;
    logic                       r_tagged;
    logic                       r_rejected;
    logic [31:0]                r_shift;
    logic [11:0]                r_vlan;
    logic [15:0]                r_link;
    logic [7:0]                 r_source;
    logic [31:0]                r_seq;

    logic [vpfp_pkg::POS_W-1:0] n_pos;
    logic                       n_tagged;
    logic                       n_rejected;
    logic [31:0]                n_shift;
    logic [11:0]                n_vlan;
    logic [15:0]                n_link;
    logic [7:0]                 n_source;
    logic [31:0]                n_seq;

    logic [vpfp_pkg::POS_W-1:0] base;
    logic [vpfp_pkg::POS_W-1:0] rel;
    logic                       frame_ok;

    always_comb begin
        n_shift    = {r_shift[23:0], i_data_byte};
        n_tagged   = r_tagged;
        n_rejected = r_rejected;
        n_vlan     = r_vlan;
        n_link     = r_link;
        n_source   = r_source;
        n_seq      = r_seq;

        if (r_pos == vpfp_pkg::POS_ETYPE_LO) begin
            if (n_shift[15:0] == vpfp_pkg::ETH_TYPE_VLAN) begin
                n_tagged = 1'b1;
            end else if (n_shift[15:0] != vpfp_pkg::ETH_TYPE_IPV4) begin
                n_rejected = 1'b1;
            end
        end else if (r_pos == vpfp_pkg::POS_VLAN_LO && r_tagged) begin
            n_vlan = n_shift[11:0];
        end

        base = n_tagged ? vpfp_pkg::HDR_TAGGED : vpfp_pkg::HDR_UNTAGGED;
        rel  = r_pos - base;

        if (r_pos >= base) begin
            case (rel)
                vpfp_pkg::REL_VERSION: begin
                    if (i_data_byte[7:4] != vpfp_pkg::IPV4_VERSION) n_rejected = 1'b1;
                end
                vpfp_pkg::REL_PROTOCOL: begin
                    if (i_data_byte != vpfp_pkg::IP_PROTO_UDP) n_rejected = 1'b1;
                end
                vpfp_pkg::REL_SRC_PORT, vpfp_pkg::REL_DST_PORT: begin
                    if (n_shift[15:0] != i_cfg.probe_port) n_rejected = 1'b1;
                end
                vpfp_pkg::REL_MAGIC: begin
                    if (n_shift != i_cfg.magic) n_rejected = 1'b1;
                end
                vpfp_pkg::REL_LINK:     n_link   = n_shift[15:0];
                vpfp_pkg::REL_SOURCE:   n_source = i_data_byte;
                vpfp_pkg::REL_SEQUENCE: n_seq    = n_shift;
                default: ;
            endcase
        end

        n_pos = (r_pos < vpfp_pkg::POS_MAX) ? r_pos + 1'b1 : r_pos;

        frame_ok = !n_rejected && (r_pos >= vpfp_pkg::POS_MIN_LAST);
        o_result.matched     = frame_ok;
        o_result.link_id     = frame_ok ? n_link   : 16'd0;
        o_result.source_port = frame_ok ? n_source : 8'd0;
        o_result.seq_number  = frame_ok ? n_seq    : 32'd0;
        o_result.vlan_id     = (frame_ok && n_tagged) ? n_vlan : 12'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos      <= '0;
            r_tagged   <= 1'b0;
            r_rejected <= 1'b0;
            r_shift    <= '0;
            r_vlan     <= '0;
            r_link     <= '0;
            r_source   <= '0;
            r_seq      <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_tagged   <= n_tagged;
            r_rejected <= n_rejected;
            r_shift    <= n_shift;
            r_vlan     <= n_vlan;
            r_link     <= n_link;
            r_source   <= n_source;
            r_seq      <= n_seq;
        end
    end

endmodule
`default_nettype wire

// ----- sv/vl_probe_frame_parser_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vl_probe_frame_parser_top
// Byte-serial parser for virtual-link UDP probe frames.
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle, one transfer per clock sustained unless a
// last byte is stalled. Each byte goes through a single pass of compare and
// capture logic against the parse state; the byte marked last loads the
// result register, whose transfer is offered on the next cycle. Only a last
// byte waits for the result register: it stalls while that register is full
// and its transfer is stalled, so a frame's body keeps streaming meanwhile.
// Registers: expected_magic at 0x0, probe_udp_port at 0x4.
// ---------------------------------------------------------------------------
module vl_probe_frame_parser_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vpfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_last_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_matched,
    output logic      [15:0]                 o_link_id,
    output logic      [7:0]                  o_source_port,
    output logic      [31:0]                 o_seq_number,
    output logic      [11:0]                 o_vlan_id
);

    vpfp_pkg::t_cfg    cfg;
    vpfp_pkg::t_result result;
    vpfp_pkg::t_result r_out;
    logic              r_out_valid;
    logic              in_accept;
    logic              out_busy;

    vpfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vpfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = out_busy && i_last_byte;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_matched     = r_out.matched;
    assign o_link_id     = r_out.link_id;
    assign o_source_port = r_out.source_port;
    assign o_seq_number  = r_out.seq_number;
    assign o_vlan_id     = r_out.vlan_id;

endmodule
`default_nettype wire
